// File: design/lcc_pkg.sv
// lcc_pkg: shared types and constants of the lux conversion and correction pipeline
// fixed-point coefficients, pipeline widths, register map and stage bundles
// no dependencies
`default_nettype none

package lcc_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam int BASE_BITS = 25;
  localparam logic [BASE_BITS-1:0] LUX_BASE = 25'd18296561;
  localparam int FRAC_BITS = 32;

  localparam int LUX_BITS = 16;
  localparam logic [LUX_BITS-1:0] LUX_MAX = 16'hFFFF;
  localparam logic [LUX_BITS-1:0] COMP_THRESHOLD = 16'd10000;

  localparam int ACC1_BITS = 25;
  localparam int ACC2_BITS = 40;
  localparam int ACC2_FULL_BITS = 42;
  localparam int P1_BITS = 56;
  localparam int HI_BITS = 40;
  localparam int LO_BITS = 48;
  localparam int SUM_BITS = 41;

  localparam logic [7:0]  COEF4 = 8'd169;
  localparam logic [21:0] COEF3 = 22'd2643726;
  localparam logic [34:0] COEF2 = 35'd22936832902;
  localparam logic [48:0] COEF1 = 49'd282122369157091;

  localparam logic [1:0] GAIN_MAX_VALID = 2'd2;
  localparam logic [2:0] ITC_MAX_VALID = 3'd4;

  localparam int PADDR_BITS = 3;
  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_ITC = 1'b1;

  typedef enum logic [1:0] {
    MODE_PASS = 2'd0,
    MODE_CORR = 2'd1,
    MODE_SAT  = 2'd2,
    MODE_ERR  = 2'd3
  } lux_mode_t;

  typedef struct packed {
    logic [1:0] gain;
    logic [2:0] itc;
  } lcc_cfg_t;

  typedef struct packed {
    logic                valid;
    lux_mode_t           mode;
    logic [LUX_BITS-1:0] x;
  } lcc_item_t;

endpackage

`default_nettype wire

// File: design/lcc_regs.sv
// lcc_regs: apb-style configuration registers for gain and integration time codes
// depends on lcc_pkg
`default_nettype none

module lcc_regs
  import lcc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_BITS-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  output lcc_cfg_t                   cfg
);

  logic [1:0] gain_r, gain_nxt;
  logic [2:0] itc_r, itc_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    gain_nxt = gain_r;
    itc_nxt  = itc_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_GAIN: gain_nxt = pwdata[1:0];
        REG_ITC:  itc_nxt  = pwdata[2:0];
        default:  gain_nxt = gain_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= 2'd0;
      itc_r  <= 3'd3;
    end else begin
      gain_r <= gain_nxt;
      itc_r  <= itc_nxt;
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_GAIN: prdata = {30'd0, gain_r};
      REG_ITC:  prdata = {29'd0, itc_r};
      default:  prdata = 32'd0;
    endcase
  end

  assign cfg.gain = gain_r;
  assign cfg.itc  = itc_r;

endmodule

`default_nettype wire

// File: design/lcc_convert.sv
// lcc_convert: count times scaled conversion factor, then range classification
// two register stages; depends on lcc_pkg
`default_nettype none

module lcc_convert
  import lcc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic [COUNT_BITS-1:0] in_count,
  input  wire lcc_cfg_t              cfg,
  output lcc_item_t                  item
);

  localparam int PW = COUNT_BITS + BASE_BITS;

  logic          s1_valid_r;
  logic [PW-1:0] s1_prod_r, s1_prod_nxt;
  logic [2:0]    s1_k_r, s1_k_nxt;
  logic          s1_err_r, s1_err_nxt;

  lcc_item_t     s2_r, s2_nxt;
  logic [5:0]    shamt;
  logic [PW-1:0] lux_wide;

  // stage 1: product with the base factor, exponent and error flag from the codes
  always_comb begin
    s1_prod_nxt = PW'(in_count) * PW'(LUX_BASE);
    s1_err_nxt  = (cfg.gain > GAIN_MAX_VALID) || (cfg.itc > ITC_MAX_VALID);
    s1_k_nxt    = 3'(2'd2 - cfg.gain) + 3'(ITC_MAX_VALID - cfg.itc);
  end

  // stage 2: drop fraction bits, decide error, saturate, correct or pass
  always_comb begin
    shamt    = 6'(FRAC_BITS) - 6'(s1_k_r);
    lux_wide = s1_prod_r >> shamt;
    s2_nxt.valid = s1_valid_r;
    s2_nxt.x     = lux_wide[LUX_BITS-1:0];
    priority if (s1_err_r) begin
      s2_nxt.mode = MODE_ERR;
    end else if (|lux_wide[PW-1:LUX_BITS]) begin
      s2_nxt.mode = MODE_SAT;
    end else if (lux_wide[LUX_BITS-1:0] > COMP_THRESHOLD) begin
      s2_nxt.mode = MODE_CORR;
    end else begin
      s2_nxt.mode = MODE_PASS;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_r.valid <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
      s2_r.valid <= s2_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_prod_r <= s1_prod_nxt;
    s1_k_r    <= s1_k_nxt;
    s1_err_r  <= s1_err_nxt;
    s2_r.mode <= s2_nxt.mode;
    s2_r.x    <= s2_nxt.x;
  end

  assign item = s2_r;

endmodule

`default_nettype wire

// File: design/lcc_correct.sv
// lcc_correct: quartic correction by horner steps, one multiply per stage but two in the hi/lo stage
// five register stages ending in the result register; depends on lcc_pkg
`default_nettype none

module lcc_correct
  import lcc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lcc_item_t            item,
  output logic                      out_strobe,
  output logic      [LUX_BITS-1:0]  out_lux,
  output logic                      out_setting_error
);

  localparam int NSTG = 4;

  logic [NSTG-1:0]     vld_r;
  lux_mode_t           mode_r [NSTG];
  logic [LUX_BITS-1:0] x_r [NSTG];

  logic [ACC1_BITS-1:0]             acc1_r, acc1_nxt;
  logic [ACC2_BITS-1:0]             acc2_r, acc2_nxt;
  logic signed [ACC2_FULL_BITS-1:0] acc2_full;
  logic [P1_BITS-1:0]               p1_r, p1_nxt;
  logic [HI_BITS-1:0]               hi_r, hi_nxt;
  logic [LO_BITS-1:0]               lo_r, lo_nxt;
  logic [SUM_BITS-1:0]              sum;
  logic [SUM_BITS-17:0]             res;

  logic                out_strobe_r;
  logic [LUX_BITS-1:0] out_lux_r, out_lux_nxt;
  logic                out_err_r, out_err_nxt;

  always_comb begin
    acc1_nxt  = ACC1_BITS'(ACC1_BITS'(item.x) * ACC1_BITS'(COEF4)) - ACC1_BITS'(COEF3);
    acc2_full = $signed(acc1_r) * $signed({1'b0, x_r[0]})
              + $signed(ACC2_FULL_BITS'(COEF2));
    acc2_nxt  = acc2_full[ACC2_BITS-1:0];
    p1_nxt    = P1_BITS'(acc2_r) * P1_BITS'(x_r[1]) + P1_BITS'(COEF1);
    hi_nxt    = HI_BITS'(p1_r[P1_BITS-1:32]) * HI_BITS'(x_r[2]);
    lo_nxt    = LO_BITS'(p1_r[31:0]) * LO_BITS'(x_r[2]);
    sum       = SUM_BITS'(hi_r) + SUM_BITS'(lo_r[LO_BITS-1:32]);
    res       = sum[SUM_BITS-1:16];
  end

  always_comb begin
    out_err_nxt = 1'b0;
    unique case (mode_r[NSTG-1])
      MODE_PASS: out_lux_nxt = x_r[NSTG-1];
      MODE_CORR: out_lux_nxt = (|res[SUM_BITS-17:LUX_BITS]) ? LUX_MAX : res[LUX_BITS-1:0];
      MODE_SAT:  out_lux_nxt = LUX_MAX;
      MODE_ERR: begin
        out_lux_nxt = '0;
        out_err_nxt = 1'b1;
      end
      default:   out_lux_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      vld_r        <= {vld_r[NSTG-2:0], item.valid};
      out_strobe_r <= vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    mode_r[0] <= item.mode;
    x_r[0]    <= item.x;
    for (int i = 1; i < NSTG; i++) begin
      mode_r[i] <= mode_r[i-1];
      x_r[i]    <= x_r[i-1];
    end
    acc1_r    <= acc1_nxt;
    acc2_r    <= acc2_nxt;
    p1_r      <= p1_nxt;
    hi_r      <= hi_nxt;
    lo_r      <= lo_nxt;
    out_lux_r <= out_lux_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_strobe        = out_strobe_r;
  assign out_lux           = out_lux_r;
  assign out_setting_error = out_err_r;

endmodule

`default_nettype wire

// File: design/lux_convert_compensate.sv
// lux_convert_compensate: raw light count to lux with quartic high-range correction
// path: a count taken at one edge goes through the convert and correct registers and shows on out_* for one cycle
// throughput: one count per cycle, busy stays low; multiply stages set the depth
// reset: synchronous active-low rst_n, gain code 0, integration code 3, pipeline empty
// depends on lcc_pkg, lcc_regs, lcc_convert, lcc_correct
`default_nettype none

module lux_convert_compensate
  import lcc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COUNT_BITS-1:0] in_raw_count,
  output logic                       out_strobe,
  output logic      [LUX_BITS-1:0]   out_lux,
  output logic                       out_setting_error,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_BITS-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready
);

  lcc_cfg_t  cfg;
  lcc_item_t item;
  logic      beat_in;

  assign busy    = 1'b0;
  assign beat_in = start & ~busy;

  lcc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lcc_convert #(
    .COUNT_BITS (COUNT_BITS)
  ) u_convert (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (beat_in),
    .in_count (in_raw_count),
    .cfg      (cfg),
    .item     (item)
  );

  lcc_correct u_correct (
    .clk               (clk),
    .rst_n             (rst_n),
    .item              (item),
    .out_strobe        (out_strobe),
    .out_lux           (out_lux),
    .out_setting_error (out_setting_error)
  );

endmodule

`default_nettype wire

// File: dv/lux_convert_compensate_tb.sv
// lux_convert_compensate_tb: self-checking bench for the lux conversion and correction pipeline
// drives counts and apb register writes, predicts lux per beat and checks every output beat
// depends on lcc_pkg and lux_convert_compensate
`default_nettype none

module lux_convert_compensate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcc_pkg::*;

  localparam int CNT_W = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 12;

  localparam logic [PADDR_BITS-1:0] ADDR_GAIN = {REG_GAIN, 2'b00};
  localparam logic [PADDR_BITS-1:0] ADDR_ITC  = {REG_ITC, 2'b00};

  localparam logic [63:0] BASE_Q32 = 64'd18296561;
  localparam logic [63:0] KNEE_LUX = 64'd10000;
  localparam logic signed [127:0] K4 = 128'sd169;
  localparam logic signed [127:0] K3 = 128'sd2643726;
  localparam logic signed [127:0] K2 = 128'sd22936832902;
  localparam logic signed [127:0] K1 = 128'sd282122369157091;

  typedef struct packed {
    logic [LUX_BITS-1:0] lux;
    logic                err;
  } lux_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CNT_W-1:0] in_raw_count = '0;
  logic out_strobe;
  logic [LUX_BITS-1:0] out_lux;
  logic out_setting_error;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic [CNT_W-1:0] count_q[$];
  lux_beat_t lux_due_q[$];
  logic [1:0] cfg_gain = 2'd0;
  logic [2:0] cfg_itc = 3'd3;
  logic idle_on = 1'b1;
  int gap_left = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;

  lux_convert_compensate #(.COUNT_BITS(CNT_W)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_raw_count(in_raw_count),
    .out_strobe(out_strobe),
    .out_lux(out_lux),
    .out_setting_error(out_setting_error),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic lux_beat_t predict_lux(logic [CNT_W-1:0] count, logic [1:0] gain,
                                            logic [2:0] itc);
    lux_beat_t r;
    int k;
    logic [63:0] factor;
    logic [63:0] lux;
    logic signed [127:0] x;
    logic signed [127:0] acc;
    r.lux = '0;
    r.err = 1'b1;
    if (gain > 2'd2 || itc > 3'd4) return r;
    k = (2 - int'(gain)) + (4 - int'(itc));
    factor = BASE_Q32 << k;
    lux = ({48'd0, count} * factor) >> 32;
    if (lux > KNEE_LUX) begin
      x = $signed({64'd0, lux});
      acc = K4 * x - K3;
      acc = acc * x + K2;
      acc = acc * x + K1;
      acc = (acc * x) >>> 48;
      lux = (acc > 128'sd65535) ? 64'd65535 : acc[63:0];
    end
    if (lux > 64'd65535) lux = 64'd65535;
    r.lux = lux[LUX_BITS-1:0];
    r.err = 1'b0;
    return r;
  endfunction

  // smallest count whose lux is above the knee at shift k
  function automatic int knee_count(int k);
    logic [63:0] factor;
    factor = BASE_Q32 << k;
    return int'((((KNEE_LUX + 64'd1) << 32) + factor - 64'd1) / factor);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      if (start && !busy)
        lux_due_q.push_back(predict_lux(in_raw_count, cfg_gain, cfg_itc));
      if (!start || !busy) begin
        if (gap_left != 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (count_q.size() != 0) begin
          start <= 1'b1;
          in_raw_count <= count_q.pop_front();
          gap_left <= idle_on ? $urandom_range(0, 3) : 0;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    lux_beat_t want;
    if (rst_n && out_strobe) begin
      if (lux_due_q.size() == 0) begin
        $error("unexpected beat: lux %0d setting_error %0b", out_lux, out_setting_error);
        mismatch_count++;
      end else begin
        want = lux_due_q.pop_front();
        if (out_lux !== want.lux) begin
          $error("lux: expected %0d, actual %0d", want.lux, out_lux);
          mismatch_count++;
        end
        if (out_setting_error !== want.err) begin
          $error("setting_error: expected %0b, actual %0b", want.err, out_setting_error);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic wait_drain();
    @(negedge clk);
    while (count_q.size() != 0 || lux_due_q.size() != 0 || start) @(negedge clk);
  endtask

  task automatic cfg_write(logic [PADDR_BITS-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // upper data bits are random, only the low code bits land in the register
  task automatic set_codes(logic [1:0] gain, logic [2:0] itc);
    wait_drain();
    cfg_write(ADDR_GAIN, ($urandom & ~32'h3) | {30'd0, gain});
    cfg_gain = gain;
    cfg_write(ADDR_ITC, ($urandom & ~32'h7) | {29'd0, itc});
    cfg_itc = itc;
  endtask

  initial begin
    int knee;
    int sel;
    logic [1:0] g;
    logic [2:0] t;
    knee = knee_count(6);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset codes
    count_q.push_back(16'd0);
    count_q.push_back(16'd1);
    count_q.push_back(16'hFFFF);
    count_q.push_back(16'h5555);
    count_q.push_back(16'hAAAA);

    // widest factor, across the correction knee
    set_codes(2'd0, 3'd0);
    count_q.push_back(16'd0);
    count_q.push_back(16'hFFFF);
    count_q.push_back(CNT_W'(knee - 1));
    count_q.push_back(CNT_W'(knee));
    count_q.push_back(CNT_W'(knee + 1));
    count_q.push_back(16'h7FFF);
    count_q.push_back(16'h8000);

    set_codes(2'd3, 3'd0);
    count_q.push_back(16'd0);
    count_q.push_back(16'hFFFF);

    set_codes(2'd0, 3'd7);
    count_q.push_back(16'hFFFF);
    count_q.push_back(16'd1234);

    set_codes(2'd2, 3'd4);
    count_q.push_back(16'hFFFF);
    count_q.push_back(16'd1);

    set_codes(2'd1, 3'd5);
    count_q.push_back(16'd4321);

    for (int ph = 0; ph < 22; ph++) begin
      if (ph % 2 == 0) begin
        g = 2'd0;
        t = 3'd0;
      end else begin
        g = $urandom_range(0, 3);
        t = $urandom_range(0, 7);
      end
      set_codes(g, t);
      idle_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 25; i++) begin
        sel = $urandom_range(0, 3);
        if (g != 2'd0 || t != 3'd0 || sel == 0)
          count_q.push_back(CNT_W'($urandom));
        else if (sel == 1)
          count_q.push_back(CNT_W'($urandom_range(knee - 64, knee + 64)));
        else
          count_q.push_back(CNT_W'($urandom_range(knee, 65535)));
      end
    end

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
